// ===== sv/prtb_pkg.sv =====
// Shared types and constants for the prescaled reload timer bank.
// No dependencies; used by prtb_addr_dec, prtb_rem_unit and the top level.
`default_nettype none

package prtb_pkg;

  // Fixed widths of the bus fields and of the per-timer state.
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CYC_W   = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned DVS_W   = CNT_W + 1;
  localparam int unsigned CTRL_W  = 32;
  localparam int unsigned PRE_W   = 10;
  localparam int unsigned ACC_W   = CYC_W + 1;
  localparam int unsigned IRQ_W   = 3;
  localparam int unsigned DIN_W   = 32;
  localparam int unsigned DOUT_W  = 16;
  localparam int unsigned MODE_W  = 2;

  // Item kinds carried in tuser.
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  // Word offsets within one timer block.
  localparam logic [1:0] WORD_PERIOD  = 2'd0;
  localparam logic [1:0] WORD_COUNT   = 2'd1;
  localparam logic [1:0] WORD_CONTROL = 2'd2;

  // Register selection decoded from a byte address.
  typedef struct packed {
    logic       mapped;
    logic [1:0] word;
    logic [1:0] lane;
  } reg_sel_t;

  // Request to the shared remainder unit.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } rem_req_t;

endpackage

`default_nettype wire

// ===== sv/prtb_addr_dec.sv =====
// Byte address decoder: splits an address into timer index, word and byte lane.
// Depends on prtb_pkg for the selection struct.
`default_nettype none

module prtb_addr_dec #(
  parameter int NUM_TIMERS  = 3,
  parameter int BLOCK_BYTES = 16,
  parameter int IDX_W       = 2
) (
  input  wire logic [prtb_pkg::ADDR_W-1:0] address,
  output logic [IDX_W-1:0]                 idx,
  output prtb_pkg::reg_sel_t               sel
);

  logic [3:0] blk;
  logic [9:0] off;
  logic [5:0] local_off;

  // The block number is the count of block boundaries at or below the address.
  always_comb begin
    blk = '0;
    for (int k = 1; k <= NUM_TIMERS; k++) begin
      if ({2'b00, address} >= 10'(k * BLOCK_BYTES)) begin
        blk = blk + 4'd1;
      end
    end
    off       = {2'b00, address} - 10'(32'(blk) * BLOCK_BYTES);
    local_off = off[5:0];
    idx        = blk[IDX_W-1:0];
    sel.lane   = local_off[1:0];
    sel.word   = local_off[3:2];
    sel.mapped = (32'(blk) < NUM_TIMERS) && (local_off[5:2] < 4'd3);
  end

endmodule

`default_nettype wire

// ===== sv/prtb_rem_unit.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on prtb_pkg for widths and the request struct.
`default_nettype none

module prtb_rem_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire prtb_pkg::rem_req_t         req,
  output logic                            done,
  output logic [prtb_pkg::CNT_W-1:0]      rem
);

  localparam int unsigned CNT_BITS = $clog2(prtb_pkg::CNT_W + 1);

  logic [prtb_pkg::CNT_W-1:0] shreg;
  logic [prtb_pkg::DVS_W-1:0] divisor;
  logic [CNT_BITS-1:0]        steps;
  logic                       busy;
  logic [prtb_pkg::DVS_W-1:0] trial;
  logic [prtb_pkg::DVS_W:0]   diff;

  // The partial remainder stays below the divisor, so it fits the count width.
  always_comb begin
    trial = {rem, shreg[prtb_pkg::CNT_W-1]};
    diff  = {1'b0, trial} - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        steps   <= CNT_BITS'(prtb_pkg::CNT_W);
        shreg   <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        shreg <= {shreg[prtb_pkg::CNT_W-2:0], 1'b0};
        if (!diff[prtb_pkg::DVS_W]) begin
          rem <= diff[prtb_pkg::CNT_W-1:0];
        end else begin
          rem <= trial[prtb_pkg::CNT_W-1:0];
        end
        steps <= steps - 1'b1;
        if (steps == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/prescaled_reload_timer_bank.sv =====
// Top level of the prescaled reload timer bank: sequencer, timer state and stream ports.
// Depends on prtb_pkg, prtb_addr_dec and prtb_rem_unit.
//
//  Channel | Signals                          | Contents (lowest bit first)
//  --------+----------------------------------+-----------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser | tuser: mode; tdata: address, write_byte,
//          |                                  |        elapsed_cycles
//  out     | m_tvalid m_tready m_tdata        | tdata: read_byte, irq_raised, zero fill
//
// Every input beat gives one output beat. A byte read or write goes through the access state
// to the final state; a tick visits each timer in the prepare state, passes a running one on
// to the compare state and an expiring one on to the divide state, as the reload wrap is a
// remainder worked out by the shared unit one bit per cycle. The bank is not ready while a
// beat is in work; a stalled result only holds the next beat in its final state.
// Reset clears all timer state, the sequencer and the output valid.
`default_nettype none

module prescaled_reload_timer_bank #(
  parameter int NUM_TIMERS  = 3,
  parameter int BLOCK_BYTES = 16,
  parameter int ENABLE_BIT  = 2,
  parameter int CYCLE_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // address [7:0], write_byte [15:8], elapsed_cycles [31:16]
  input  wire logic [prtb_pkg::DIN_W-1:0]   s_tdata,
  // mode [1:0]
  input  wire logic [prtb_pkg::MODE_W-1:0]  s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // read_byte [7:0], irq_raised [10:8], zero [15:11]
  output logic [prtb_pkg::DOUT_W-1:0]       m_tdata
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [prtb_pkg::CYC_W-1:0] CYC_MASK =
    (CYCLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << CYCLE_BITS) - 32'd1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ACCESS = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_CMP    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state;

  // Per-timer architectural state.
  logic [prtb_pkg::CNT_W-1:0]  period  [NUM_TIMERS];
  logic [prtb_pkg::CNT_W-1:0]  count   [NUM_TIMERS];
  logic [prtb_pkg::CTRL_W-1:0] control [NUM_TIMERS];
  logic [prtb_pkg::PRE_W-1:0]  accum   [NUM_TIMERS];

  // Registers of the beat in work.
  logic [IDX_W-1:0]                cur;
  logic [prtb_pkg::MODE_W-1:0]     mode;
  prtb_pkg::reg_sel_t              sel;
  logic [prtb_pkg::BYTE_W-1:0]     wbyte;
  logic [prtb_pkg::CYC_W-1:0]      cycles;
  logic [prtb_pkg::CNT_W-1:0]      ticks;
  logic [prtb_pkg::BYTE_W-1:0]     rd;
  logic [prtb_pkg::IRQ_W-1:0]      irq;

  // Decoder and remainder unit connections.
  logic [IDX_W-1:0]           dec_idx;
  prtb_pkg::reg_sel_t         dec_sel;
  prtb_pkg::rem_req_t         rem_req;
  logic                       rem_done;
  logic [prtb_pkg::CNT_W-1:0] rem_val;

  // Combinational views of the selected timer.
  logic [prtb_pkg::CNT_W-1:0]  cur_period;
  logic [prtb_pkg::CNT_W-1:0]  cur_count;
  logic [prtb_pkg::CTRL_W-1:0] cur_ctrl;
  logic [prtb_pkg::PRE_W-1:0]  cur_accum;
  logic [prtb_pkg::CTRL_W-1:0] word_val;
  logic [prtb_pkg::BYTE_W-1:0] read_val;
  logic [prtb_pkg::CTRL_W-1:0] ctrl_wr;
  logic                        en_rise;
  logic [prtb_pkg::ACC_W-1:0]  acc;
  logic [prtb_pkg::CNT_W-1:0]  ticks_next;
  logic [prtb_pkg::PRE_W-1:0]  accum_next;
  logic                        running;
  logic                        expire;
  logic                        last_timer;
  logic                        out_free;

  prtb_addr_dec #(
    .NUM_TIMERS  (NUM_TIMERS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .IDX_W       (IDX_W)
  ) u_dec (
    .address (s_tdata[7:0]),
    .idx     (dec_idx),
    .sel     (dec_sel)
  );

  prtb_rem_unit u_rem (
    .clk  (clk),
    .rst  (rst),
    .req  (rem_req),
    .done (rem_done),
    .rem  (rem_val)
  );

  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign last_timer = (32'(cur) == NUM_TIMERS - 1);

  always_comb begin
    cur_period = period[cur];
    cur_count  = count[cur];
    cur_ctrl   = control[cur];
    cur_accum  = accum[cur];

    // Period and count are sixteen bits wide, so their upper lanes read as zero.
    unique case (sel.word)
      prtb_pkg::WORD_PERIOD:  word_val = {16'h0000, cur_period};
      prtb_pkg::WORD_COUNT:   word_val = {16'h0000, cur_count};
      prtb_pkg::WORD_CONTROL: word_val = cur_ctrl;
      default:                word_val = '0;
    endcase
    case (sel.lane)
      2'd0:    read_val = word_val[7:0];
      2'd1:    read_val = word_val[15:8];
      2'd2:    read_val = word_val[23:16];
      default: read_val = word_val[31:24];
    endcase

    ctrl_wr = cur_ctrl;
    case (sel.lane)
      2'd0:    ctrl_wr[7:0]   = wbyte;
      2'd1:    ctrl_wr[15:8]  = wbyte;
      2'd2:    ctrl_wr[23:16] = wbyte;
      default: ctrl_wr[31:24] = wbyte;
    endcase
    en_rise = !cur_ctrl[ENABLE_BIT] && ctrl_wr[ENABLE_BIT];

    // Prescaler: the divisors are powers of two, so whole ticks are a shift of the
    // accumulated cycles and the carried remainder is the bits shifted out.
    acc = prtb_pkg::ACC_W'(cur_accum) + prtb_pkg::ACC_W'(cycles);
    case (cur_ctrl[1:0])
      2'd1: begin
        ticks_next = {4'b0000, acc[16:5]};
        accum_next = {5'b00000, acc[4:0]};
      end
      2'd2: begin
        ticks_next = {8'h00, acc[16:9]};
        accum_next = {1'b0, acc[8:0]};
      end
      default: begin
        ticks_next = acc[16:1];
        accum_next = {9'b000000000, acc[0]};
      end
    endcase

    running = cur_ctrl[ENABLE_BIT] && (cur_period != '0);
    expire  = ticks > cur_count;

    // Ticks left after the first expiry wrap modulo period plus one.
    rem_req.start    = (state == ST_CMP) && expire;
    rem_req.dividend = ticks - cur_count - 1'b1;
    rem_req.divisor  = {1'b0, cur_period} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      cur      <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        period[i]  <= '0;
        count[i]   <= '0;
        control[i] <= '0;
        accum[i]   <= '0;
      end
    end else begin
      // The final state raises the valid itself, so the clear is left out there.
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode   <= s_tuser;
            sel    <= dec_sel;
            wbyte  <= s_tdata[15:8];
            cycles <= s_tdata[31:16] & CYC_MASK;
            rd     <= '0;
            irq    <= '0;
            if (s_tuser == prtb_pkg::MODE_READ || s_tuser == prtb_pkg::MODE_WRITE) begin
              cur   <= dec_idx;
              state <= ST_ACCESS;
            end else if (s_tuser == prtb_pkg::MODE_TICK) begin
              cur   <= '0;
              state <= ST_PREP;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_ACCESS: begin
          if (sel.mapped) begin
            if (mode == prtb_pkg::MODE_READ) begin
              rd <= read_val;
            end else begin
              unique case (sel.word)
                prtb_pkg::WORD_PERIOD: begin
                  if (sel.lane == 2'd0) period[cur][7:0]  <= wbyte;
                  if (sel.lane == 2'd1) period[cur][15:8] <= wbyte;
                end
                prtb_pkg::WORD_COUNT: begin
                  if (sel.lane == 2'd0) count[cur][7:0]  <= wbyte;
                  if (sel.lane == 2'd1) count[cur][15:8] <= wbyte;
                end
                prtb_pkg::WORD_CONTROL: begin
                  control[cur] <= ctrl_wr;
                  accum[cur]   <= '0;
                  if (en_rise) begin
                    count[cur] <= cur_period;
                  end
                end
                default: ;
              endcase
            end
          end
          state <= ST_FIN;
        end
        ST_PREP: begin
          if (running) begin
            ticks      <= ticks_next;
            accum[cur] <= accum_next;
            state      <= ST_CMP;
          end else if (last_timer) begin
            state <= ST_FIN;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        ST_CMP: begin
          if (expire) begin
            // Only the first three timers have a place in the interrupt field.
            for (int b = 0; b < prtb_pkg::IRQ_W; b++) begin
              if (32'(cur) == b) begin
                irq[b] <= 1'b1;
              end
            end
            state <= ST_DIV;
          end else begin
            count[cur] <= cur_count - ticks;
            if (last_timer) begin
              state <= ST_FIN;
            end else begin
              cur   <= cur + 1'b1;
              state <= ST_PREP;
            end
          end
        end
        ST_DIV: begin
          if (rem_done) begin
            count[cur] <= cur_period - rem_val;
            if (last_timer) begin
              state <= ST_FIN;
            end else begin
              cur   <= cur + 1'b1;
              state <= ST_PREP;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload is loaded as the sequencer leaves its final state.
  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= {5'b00000, irq, rd};
    end
  end

endmodule

`default_nettype wire

// ===== sim/prtb_checker.sv =====
// Scoreboard for the prescaled reload timer bank: watches both stream channels, keeps its own
// copy of the timer state, predicts each result beat and compares it field by field.
// Depends on prtb_pkg for the field widths, item kinds and word offsets.
module prtb_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  input  wire logic                         s_tready,
  // address [7:0], write_byte [15:8], elapsed_cycles [31:16]
  input  wire logic [prtb_pkg::DIN_W-1:0]   s_tdata,
  // mode [1:0]
  input  wire logic [prtb_pkg::MODE_W-1:0]  s_tuser,
  input  wire logic                         m_tvalid,
  input  wire logic                         m_tready,
  // read_byte [7:0], irq_raised [10:8], zero [15:11]
  input  wire logic [prtb_pkg::DOUT_W-1:0]  m_tdata,
  output int                                mismatches,
  output int                                outstanding
);
  import prtb_pkg::*;

  localparam int NUM_TIMERS  = 3;
  localparam int BLOCK_BYTES = 16;
  localparam int ENABLE_BIT  = 2;

  // Prescaler select codes in control bits 1:0; anything else divides by two.
  localparam logic [1:0] PRESCALE_32  = 2'd1;
  localparam logic [1:0] PRESCALE_512 = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] rd;
    logic [IRQ_W-1:0]  irq;
  } timer_result_t;

  logic [CNT_W-1:0]  period_q   [NUM_TIMERS];
  logic [CNT_W-1:0]  count_q    [NUM_TIMERS];
  logic [CTRL_W-1:0] ctrl_q     [NUM_TIMERS];
  int unsigned       prescale_q [NUM_TIMERS];
  timer_result_t     awaited_results [$];
  int                fail_count;

  function automatic logic [BYTE_W-1:0] fetch_bus_byte(input logic [ADDR_W-1:0] addr);
    int unsigned       idx;
    int unsigned       word;
    int unsigned       shift;
    logic [CTRL_W-1:0] value;
    idx   = addr / BLOCK_BYTES;
    word  = (addr % BLOCK_BYTES) / 4;
    shift = (addr % 4) * 8;
    if (idx >= NUM_TIMERS) return '0;
    case (word)
      WORD_PERIOD:  value = CTRL_W'(period_q[idx]);
      WORD_COUNT:   value = CTRL_W'(count_q[idx]);
      WORD_CONTROL: value = ctrl_q[idx];
      default:      value = '0;
    endcase
    value = value >> shift;
    return value[BYTE_W-1:0];
  endfunction

  task automatic apply_bus_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
    int unsigned idx;
    int unsigned word;
    int unsigned lane;
    logic        was_on;
    idx  = addr / BLOCK_BYTES;
    word = (addr % BLOCK_BYTES) / 4;
    lane = addr % 4;
    if (idx >= NUM_TIMERS) return;
    case (word)
      WORD_PERIOD: if (lane < 2) period_q[idx][lane*8 +: 8] = data;
      WORD_COUNT:  if (lane < 2) count_q[idx][lane*8 +: 8] = data;
      WORD_CONTROL: begin
        was_on = ctrl_q[idx][ENABLE_BIT];
        ctrl_q[idx][lane*8 +: 8] = data;
        prescale_q[idx] = 0;
        if (!was_on && ctrl_q[idx][ENABLE_BIT]) count_q[idx] = period_q[idx];
      end
      default: ;
    endcase
  endtask

  task automatic advance_timers(input logic [CYC_W-1:0] cycles, output logic [IRQ_W-1:0] fired);
    int unsigned divisor;
    int unsigned total;
    int unsigned ticks;
    fired = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      if (ctrl_q[t][ENABLE_BIT] && period_q[t] != '0) begin
        case (ctrl_q[t][1:0])
          PRESCALE_32:  divisor = 32;
          PRESCALE_512: divisor = 512;
          default:      divisor = 2;
        endcase
        total         = prescale_q[t] + cycles;
        ticks         = total / divisor;
        prescale_q[t] = total % divisor;
        if (ticks > count_q[t]) begin
          // The first expiry uses up count+1 ticks; the rest wrap on period+1.
          ticks = (ticks - count_q[t] - 1) % (period_q[t] + 1);
          count_q[t] = period_q[t] - ticks[CNT_W-1:0];
          if (t < IRQ_W) fired[t] = 1'b1;
        end else begin
          count_q[t] = count_q[t] - ticks[CNT_W-1:0];
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    timer_result_t     want;
    logic [IRQ_W-1:0]  fired;
    logic [BYTE_W-1:0] got_rd;
    logic [IRQ_W-1:0]  got_irq;
    if (rst) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        period_q[t]   = '0;
        count_q[t]    = '0;
        ctrl_q[t]     = '0;
        prescale_q[t] = 0;
      end
      awaited_results.delete();
      fail_count = 0;
    end else begin
      // A result never leaves in the cycle its own beat arrives, so outputs are checked first.
      if (m_tvalid && m_tready) begin
        got_rd  = m_tdata[BYTE_W-1:0];
        got_irq = m_tdata[BYTE_W +: IRQ_W];
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with none due, expected none, got %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got_rd !== want.rd) begin
            $display("%0t: read_byte mismatch, expected %h, got %h", $time, want.rd, got_rd);
            fail_count++;
          end
          if (got_irq !== want.irq) begin
            $display("%0t: irq_raised mismatch, expected %b, got %b", $time, want.irq, got_irq);
            fail_count++;
          end
          if (m_tdata[DOUT_W-1:BYTE_W+IRQ_W] !== '0) begin
            $display("%0t: fill bits mismatch, expected 0, got %h", $time,
                     m_tdata[DOUT_W-1:BYTE_W+IRQ_W]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = '0;
        case (s_tuser)
          MODE_READ:  want.rd = fetch_bus_byte(s_tdata[ADDR_W-1:0]);
          MODE_WRITE: apply_bus_write(s_tdata[ADDR_W-1:0], s_tdata[ADDR_W +: BYTE_W]);
          MODE_TICK: begin
            advance_timers(s_tdata[ADDR_W+BYTE_W +: CYC_W], fired);
            want.irq = fired;
          end
          default: ;
        endcase
        awaited_results.push_back(want);
      end
    end
    mismatches  <= fail_count;
    outstanding <= awaited_results.size();
  end

endmodule

// ===== sim/tb_prescaled_reload_timer_bank.sv =====
// Testbench top for the prescaled reload timer bank: clock, reset, stimulus and verdict.
// Depends on prtb_pkg, the block prescaled_reload_timer_bank and the scoreboard prtb_checker.
module tb_prescaled_reload_timer_bank;
  import prtb_pkg::*;

  // The fourth item kind is unused by the block; it must change nothing and return zeros.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int ENABLE_BIT   = 2;
  localparam int RANDOM_BEATS = 2000;
  // The last stretch of the run goes without any idling on either side.
  localparam int CALM_BEATS   = 300;
  // A tick with all three timers expiring, plus the stalls on each side, stays far below this
  // limit of quiet cycles, so reaching it can only mean the block has hung.
  localparam int STUCK_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 100;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic [DIN_W-1:0]  s_tdata  = '0;
  logic [MODE_W-1:0] s_tuser  = '0;
  logic              m_tready = 1'b0;
  logic              gaps_on  = 1'b1;
  wire               s_tready;
  wire               m_tvalid;
  wire  [DOUT_W-1:0] m_tdata;
  int                mismatches;
  int                outstanding;
  int unsigned       stall_left  = 0;
  int unsigned       quiet_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  prescaled_reload_timer_bank u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  prtb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The result side stalls in bursts while idling is switched on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count == STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Offers one beat and holds it until the block takes it. The valid is only lowered when a
  // gap is inserted, so it is never dropped and raised again within the same edge.
  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic [CYC_W-1:0] cycles);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {cycles, data, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  // Random beats are mostly aimed at the live registers of the three timers, with control
  // writes that usually leave the timer enabled, so that the counters keep running and
  // expiring. The remainder reaches unmapped offsets and the spare item kind.
  task automatic send_random_beat();
    int unsigned       pick;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [CYC_W-1:0]  cycles;
    pick = $urandom_range(0, 99);
    if (pick < 30)      mode = MODE_READ;
    else if (pick < 65) mode = MODE_WRITE;
    else if (pick < 97) mode = MODE_TICK;
    else                mode = MODE_SPARE;
    if ($urandom_range(0, 9) < 8)
      addr = ADDR_W'($urandom_range(0, 2) * 16 + $urandom_range(0, 2) * 4
                     + $urandom_range(0, 3));
    else
      addr = ADDR_W'($urandom);
    data = BYTE_W'($urandom);
    if (addr < 48) begin
      // The upper byte of period and count is often zero, which keeps the periods short.
      if ((addr % 16 == 1 || addr % 16 == 5) && $urandom_range(0, 1) == 0) data = '0;
      if (addr % 16 == 8) data[ENABLE_BIT] = ($urandom_range(0, 3) != 0);
    end
    case ($urandom_range(0, 5))
      0:       cycles = '0;
      1:       cycles = '1;
      2, 3:    cycles = CYC_W'($urandom_range(0, 255));
      default: cycles = CYC_W'($urandom);
    endcase
    send_beat(mode, addr, data, cycles);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Timer 0: a period of three at divide-by-two, with the dead upper lane of the period.
    send_beat(MODE_READ,  8'h00, 8'h00, 16'h0000);
    send_beat(MODE_WRITE, 8'h00, 8'h03, 16'h0000);
    send_beat(MODE_WRITE, 8'h01, 8'h00, 16'h0000);
    send_beat(MODE_WRITE, 8'h02, 8'hAA, 16'h0000);
    send_beat(MODE_READ,  8'h02, 8'h00, 16'h0000);
    // Enabling loads the count from the period; a full-range tick then wraps many times.
    send_beat(MODE_WRITE, 8'h08, 8'h04, 16'h0000);
    send_beat(MODE_TICK,  8'h00, 8'h00, 16'hFFFF);
    send_beat(MODE_TICK,  8'h00, 8'h00, 16'h0000);
    // Timer 1: the largest period at divide-by-512, then a write to the top control byte,
    // which clears the prescaler but must not reload the count again.
    send_beat(MODE_WRITE, 8'h10, 8'hFF, 16'h0000);
    send_beat(MODE_WRITE, 8'h11, 8'hFF, 16'h0000);
    send_beat(MODE_WRITE, 8'h18, 8'h06, 16'h0000);
    send_beat(MODE_TICK,  8'h00, 8'h00, 16'h0300);
    send_beat(MODE_WRITE, 8'h1B, 8'hFF, 16'h0000);
    // Timer 2: a count well above a short period, so the first expiry is the long one.
    send_beat(MODE_WRITE, 8'h20, 8'h02, 16'h0000);
    send_beat(MODE_WRITE, 8'h28, 8'h05, 16'h0000);
    send_beat(MODE_WRITE, 8'h24, 8'hFF, 16'h0000);
    send_beat(MODE_WRITE, 8'h25, 8'hFF, 16'h0000);
    send_beat(MODE_TICK,  8'h00, 8'h00, 16'hFFFF);
    // Unmapped offsets: the fourth word of the block just past the last timer, and a block further out.
    send_beat(MODE_WRITE, 8'h3C, 8'h55, 16'h0000);
    send_beat(MODE_WRITE, 8'hF0, 8'h77, 16'h0000);
    send_beat(MODE_READ,  8'h3C, 8'h00, 16'h0000);
    send_beat(MODE_READ,  8'hF1, 8'h00, 16'h0000);
    // The spare item kind with every other field at its maximum.
    send_beat(MODE_SPARE, 8'hFF, 8'hFF, 16'hFFFF);
    send_beat(MODE_READ,  8'h1B, 8'h00, 16'h0000);
    send_beat(MODE_READ,  8'h25, 8'h00, 16'h0000);
    // A disabled timer must hold its count through a tick.
    send_beat(MODE_WRITE, 8'h08, 8'h00, 16'h0000);
    send_beat(MODE_TICK,  8'h00, 8'h00, 16'h1234);
    send_beat(MODE_READ,  8'h04, 8'h00, 16'h0000);

    // Idling is switched on or off every hundred beats and stays off for the final stretch.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0)
        gaps_on <= (n < RANDOM_BEATS - CALM_BEATS) && ($urandom_range(0, 3) != 0);
      send_random_beat();
    end
    s_tvalid <= 1'b0;

    // The count of awaited results is registered and trails the scoreboard, so an edge is stepped first.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
